### src/esss_pkg.sv
// Package for the escape sequence symbol splitter: character codes,
// escape tracking state encoding and character class functions.
// No dependencies.
`default_nettype none

package esss_pkg;

    localparam int unsigned CH_W  = 16;
    localparam int unsigned LEN_W = 3;

    localparam logic [CH_W-1:0]  BACKSLASH   = 16'h005C;
    localparam logic [CH_W-1:0]  OCT_LO      = 16'h0030;
    localparam logic [CH_W-1:0]  OCT_HI      = 16'h0037;
    localparam logic [LEN_W-1:0] OCT_MAX_LEN = 3'd4;
    localparam logic [LEN_W-1:0] LEN_SAT     = 3'd7;

    // Escape tracking state, one-hot
    typedef enum logic [3:0] {
        ESC_OUTSIDE  = 4'b0001,
        ESC_AFTER_BS = 4'b0010,
        ESC_OCTAL    = 4'b0100,
        ESC_HEX      = 4'b1000
    } t_esc_mode;

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 16'h0030) && (c <= 16'h0039);
    endfunction

    function automatic logic is_hex_char(input logic [CH_W-1:0] c);
        return is_digit(c) ||
               ((c >= 16'h0061) && (c <= 16'h0066)) ||
               ((c >= 16'h0041) && (c <= 16'h0046));
    endfunction

    // ' " ? \ a b f n r t v
    function automatic logic is_simple_esc(input logic [CH_W-1:0] c);
        return (c == 16'h0027) || (c == 16'h0022) || (c == 16'h003F) ||
               (c == BACKSLASH)  || (c == 16'h0061) || (c == 16'h0062) ||
               (c == 16'h0066) || (c == 16'h006E) || (c == 16'h0072) ||
               (c == 16'h0074) || (c == 16'h0076);
    endfunction

    // x u U
    function automatic logic is_hex_opener(input logic [CH_W-1:0] c);
        return (c == 16'h0078) || (c == 16'h0075) || (c == 16'h0055);
    endfunction

    function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] len);
        return (len < LEN_SAT) ? len + 3'd1 : len;
    endfunction

endpackage

`default_nettype wire

### src/escape_sequence_symbol_splitter.sv
// Top level of the escape sequence symbol splitter: stream in, stream out.
// Depends on esss_pkg.
`default_nettype none

// Marks the first character of every symbol in a C string literal body,
// one 16-bit character per transaction; a symbol is a plain character or
// a whole escape sequence. Each input transaction gives exactly one output
// transaction. A new character is taken every cycle unless the skid is full:
// the escape state is updated in the cycle of acceptance, the result sits in
// an output register, and a one-entry skid register keeps s_axis_tready high
// for one more transaction while the output is stalled. s_axis_tlast ends
// any open escape, so the character after it always starts a new symbol.
module escape_sequence_symbol_splitter (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [esss_pkg::CH_W-1:0] s_axis_tdata,  // [15:0] ch
    input  wire logic                    s_axis_tlast,    // last
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [esss_pkg::CH_W-1:0]    m_axis_tdata,    // [15:0] ch_out
    output logic                         m_axis_tuser,    // starts_symbol
    output logic                         m_axis_tlast     // last_out
);
    import esss_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            starts;
        logic            last;
    } t_result;

    t_esc_mode        r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic             n_starts;

    t_result r_out, r_skid, n_res;
    logic    r_out_valid, r_skid_valid;

    logic in_fire, out_fire;

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;

    always_comb begin
        logic [CH_W-1:0] c;
        logic            open_new;
        c        = s_axis_tdata;
        open_new = 1'b0;
        n_mode   = r_mode;
        n_len    = r_len;
        case (r_mode)
            ESC_AFTER_BS: begin
                if (is_digit(c)) begin
                    n_mode = ESC_OCTAL;
                    n_len  = bump(r_len);
                end else if (is_simple_esc(c)) begin
                    n_mode = ESC_OUTSIDE;
                    n_len  = '0;
                end else if (is_hex_opener(c)) begin
                    n_mode = ESC_HEX;
                    n_len  = bump(r_len);
                end else begin
                    open_new = 1'b1;
                end
            end
            ESC_OCTAL: begin
                if (c >= OCT_LO && c <= OCT_HI && r_len < OCT_MAX_LEN) begin
                    n_len = bump(r_len);
                end else begin
                    open_new = 1'b1;
                end
            end
            ESC_HEX: begin
                if (is_hex_char(c)) begin
                    n_len = bump(r_len);
                end else begin
                    open_new = 1'b1;
                end
            end
            default: begin
                open_new = 1'b1;
            end
        endcase
        if (open_new) begin
            if (c == BACKSLASH) begin
                n_mode = ESC_AFTER_BS;
                n_len  = 3'd1;
            end else begin
                n_mode = ESC_OUTSIDE;
                n_len  = '0;
            end
        end
        if (s_axis_tlast) begin
            n_mode = ESC_OUTSIDE;
            n_len  = '0;
        end
        n_starts = open_new;
        n_res    = '{ch: c, starts: n_starts, last: s_axis_tlast};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ESC_OUTSIDE;
            r_len  <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_res;
            end
        end else if (in_fire) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.ch;
    assign m_axis_tuser  = r_out.starts;
    assign m_axis_tlast  = r_out.last;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_outside_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ESC_OUTSIDE) |-> (r_len == '0))
        else $error("length nonzero outside an escape");

    a_after_bs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ESC_AFTER_BS) |-> (r_len == 3'd1))
        else $error("length wrong just after backslash");

    a_octal_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ESC_OCTAL) |-> (r_len >= 3'd2 && r_len <= OCT_MAX_LEN))
        else $error("octal run length out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tlast) |=> (r_mode == ESC_OUTSIDE))
        else $error("escape state not cleared after last");
`endif

endmodule

`default_nettype wire
